>>> src/uhjs_pkg.sv
// shared types, constants and jamo tables for the hangul jamo splitter
`timescale 1ns / 1ps
`default_nettype none

package uhjs_pkg;

  localparam logic [1:0] KIND_RAW     = 2'd0;
  localparam logic [1:0] KIND_INITIAL = 2'd1;
  localparam logic [1:0] KIND_MEDIAL  = 2'd2;
  localparam logic [1:0] KIND_FINAL   = 2'd3;

  localparam logic [15:0] SYL_FIRST   = 16'hAC00;
  localparam logic [15:0] SYL_LAST    = 16'hD7A3;
  localparam logic [3:0]  LEAD_3BYTE  = 4'hE;
  localparam logic [13:0] MEDIAL_BASE = 14'h314F;

  // reciprocals: floor(s * RECIP_588 >> 23) == s / 588 for s < 11172,
  // floor(u * RECIP_7 >> 16) == u / 7 for u < 2793
  localparam logic [13:0] RECIP_588 = 14'd14267;
  localparam logic [13:0] RECIP_7   = 14'd9363;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } uhjs_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  jamo_index;
    logic [13:0] code_value;
    logic        out_last;
  } uhjs_out_t;

  // group leaving the window: one syllable or up to three raw bytes
  typedef struct packed {
    logic        is_syl;
    logic [1:0]  nraw;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic        last;
    logic [13:0] s;
  } uhjs_grp1_t;

  // group after the reciprocal multiplies
  typedef struct packed {
    logic        is_syl;
    logic [1:0]  nraw;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic        last;
    logic [4:0]  ini;
    logic [8:0]  t;
    logic [11:0] u;
    logic [1:0]  s_lo;
  } uhjs_grp2_t;

  function automatic logic [13:0] initial_cp(input logic [4:0] idx);
    logic [13:0] cp;
    case (idx)
      5'd0:    cp = 14'h3131;
      5'd1:    cp = 14'h3132;
      5'd2:    cp = 14'h3134;
      5'd3:    cp = 14'h3137;
      5'd4:    cp = 14'h3138;
      5'd5:    cp = 14'h3139;
      5'd6:    cp = 14'h3141;
      5'd7:    cp = 14'h3142;
      5'd8:    cp = 14'h3143;
      5'd9:    cp = 14'h3145;
      5'd10:   cp = 14'h3146;
      5'd11:   cp = 14'h3147;
      5'd12:   cp = 14'h3148;
      5'd13:   cp = 14'h3149;
      5'd14:   cp = 14'h314A;
      5'd15:   cp = 14'h314B;
      5'd16:   cp = 14'h314C;
      5'd17:   cp = 14'h314D;
      5'd18:   cp = 14'h314E;
      default: cp = 14'h3131;
    endcase
    return cp;
  endfunction

  function automatic logic [13:0] final_cp(input logic [4:0] idx);
    logic [13:0] cp;
    case (idx)
      5'd1:    cp = 14'h3131;
      5'd2:    cp = 14'h3132;
      5'd3:    cp = 14'h3133;
      5'd4:    cp = 14'h3134;
      5'd5:    cp = 14'h3135;
      5'd6:    cp = 14'h3136;
      5'd7:    cp = 14'h3137;
      5'd8:    cp = 14'h3139;
      5'd9:    cp = 14'h313A;
      5'd10:   cp = 14'h313B;
      5'd11:   cp = 14'h313C;
      5'd12:   cp = 14'h313D;
      5'd13:   cp = 14'h313E;
      5'd14:   cp = 14'h313F;
      5'd15:   cp = 14'h3140;
      5'd16:   cp = 14'h3141;
      5'd17:   cp = 14'h3142;
      5'd18:   cp = 14'h3144;
      5'd19:   cp = 14'h3145;
      5'd20:   cp = 14'h3146;
      5'd21:   cp = 14'h3147;
      5'd22:   cp = 14'h3148;
      5'd23:   cp = 14'h314A;
      5'd24:   cp = 14'h314B;
      5'd25:   cp = 14'h314C;
      5'd26:   cp = 14'h314D;
      5'd27:   cp = 14'h314E;
      default: cp = 14'h0000;
    endcase
    return cp;
  endfunction

endpackage

`default_nettype wire

>>> src/uhjs_jamo_expand.sv
// turns one decoded group into its list of up to three result items
`timescale 1ns / 1ps
`default_nettype none

module uhjs_jamo_expand
  import uhjs_pkg::*;
(
  input  uhjs_grp2_t            grp_i,
  output uhjs_out_t [2:0]       res_o,
  output logic      [1:0]       cnt_o
);

  logic [9:0]  med_w;
  logic [11:0] rem_w;
  logic [4:0]  med;
  logic [4:0]  fin;
  logic        has_fin;

  // remainders from the registered quotients
  assign med_w   = 10'(grp_i.t) - 10'(grp_i.ini) * 10'd21;
  assign rem_w   = grp_i.u - 12'(grp_i.t) * 12'd7;
  assign med     = med_w[4:0];
  assign fin     = {rem_w[2:0], grp_i.s_lo};
  assign has_fin = (fin != 5'd0);

  always_comb begin
    if (grp_i.is_syl) begin
      res_o[0] = '{kind: KIND_INITIAL, jamo_index: grp_i.ini,
                   code_value: initial_cp(grp_i.ini), out_last: 1'b0};
      res_o[1] = '{kind: KIND_MEDIAL, jamo_index: med,
                   code_value: MEDIAL_BASE + 14'(med),
                   out_last: grp_i.last && !has_fin};
      res_o[2] = '{kind: KIND_FINAL, jamo_index: fin,
                   code_value: final_cp(fin), out_last: grp_i.last};
      cnt_o    = has_fin ? 2'd3 : 2'd2;
    end else begin
      res_o[0] = '{kind: KIND_RAW, jamo_index: 5'd0, code_value: 14'(grp_i.b0),
                   out_last: grp_i.last && (grp_i.nraw == 2'd1)};
      res_o[1] = '{kind: KIND_RAW, jamo_index: 5'd0, code_value: 14'(grp_i.b1),
                   out_last: grp_i.last && (grp_i.nraw == 2'd2)};
      res_o[2] = '{kind: KIND_RAW, jamo_index: 5'd0, code_value: 14'(grp_i.b2),
                   out_last: grp_i.last && (grp_i.nraw == 2'd3)};
      cnt_o    = grp_i.nraw;
    end
  end

endmodule

`default_nettype wire

>>> src/utf8_hangul_jamo_splitter_top.sv
// UTF-8 byte stream in, hangul syllables split into jamo items out
//
// Takes one UTF-8 byte per cycle into a three-byte window. A full window whose
// head is a three-byte lead decoding to 0xAC00..0xD7A3 leaves as initial,
// medial and (when nonzero) final jamo items; otherwise the head byte leaves
// raw. in_last flushes whatever the window holds. A byte is taken every cycle
// while the output drains one item per cycle; the group that a byte completes
// passes through g1, g2 and the result register before its first item appears.
// Output bandwidth sets the pace: a group of k items (a syllable or an
// end-of-text flush) holds the output until all k have left, so when the bytes
// behind it yield items right away the input is held.
`timescale 1ns / 1ps
`default_nettype none

module utf8_hangul_jamo_splitter_top
  import uhjs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  uhjs_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output uhjs_out_t out_data_o
);

  // window
  logic [7:0] win0_q, win0_d, win1_q, win1_d;
  logic [1:0] wcnt_q, wcnt_d;

  logic [7:0]  b0, b1, b2;
  logic [1:0]  n;
  logic [15:0] cp;
  logic [15:0] s_w;
  logic        syl;
  logic        grp_valid;
  uhjs_grp1_t  grp;

  // pipeline
  logic       g1_valid_q, g1_valid_d;
  uhjs_grp1_t g1_q;
  logic       g2_valid_q, g2_valid_d;
  uhjs_grp2_t g2_q, g2_d;

  logic [27:0] ini_prod;
  logic [25:0] t_prod;

  // result shift register
  uhjs_out_t [2:0] res_q, res_d;
  logic      [1:0] rcnt_q, rcnt_d;
  uhjs_out_t [2:0] exp_res;
  logic      [1:0] exp_cnt;

  logic take, load_ok, g2_free, g1_free, accept;

  assign take    = (rcnt_q != 2'd0) && !out_stall_i;
  assign load_ok = (rcnt_q == 2'd0) || ((rcnt_q == 2'd1) && !out_stall_i);
  assign g2_free = !g2_valid_q || load_ok;
  assign g1_free = !g1_valid_q || g2_free;
  assign accept  = in_valid_i && g1_free;

  assign in_stall_o  = !g1_free;
  assign out_valid_o = (rcnt_q != 2'd0);
  assign out_data_o  = res_q[0];

  // window plus the new byte
  always_comb begin
    b0 = (wcnt_q == 2'd0) ? in_data_i.in_byte : win0_q;
    b1 = (wcnt_q == 2'd0) ? 8'd0 : ((wcnt_q == 2'd1) ? in_data_i.in_byte : win1_q);
    b2 = (wcnt_q == 2'd2) ? in_data_i.in_byte : 8'd0;
    n  = (wcnt_q == 2'd2) ? 2'd3 : wcnt_q + 2'd1;
    cp = {b0[3:0], b1[5:0], b2[5:0]};
    syl = (n == 2'd3) && (b0[7:4] == LEAD_3BYTE) && (cp >= SYL_FIRST) && (cp <= SYL_LAST);
    s_w = cp - SYL_FIRST;
  end

  always_comb begin
    grp.is_syl = syl;
    grp.b0     = b0;
    grp.b1     = b1;
    grp.b2     = b2;
    grp.last   = in_data_i.in_last;
    grp.s      = s_w[13:0];
    grp.nraw   = n;
    grp_valid  = 1'b0;
    win0_d     = win0_q;
    win1_d     = win1_q;
    wcnt_d     = wcnt_q;
    if (accept) begin
      if (syl || in_data_i.in_last) begin
        grp_valid = 1'b1;
        win0_d    = 8'd0;
        win1_d    = 8'd0;
        wcnt_d    = 2'd0;
      end else if (n == 2'd3) begin
        // head byte leaves raw, window slides by one
        grp_valid = 1'b1;
        grp.nraw  = 2'd1;
        win0_d    = b1;
        win1_d    = b2;
        wcnt_d    = 2'd2;
      end else begin
        win0_d = b0;
        win1_d = b1;
        wcnt_d = n;
      end
    end
  end

  // quotients s / 588 and (s / 4) / 7 by reciprocal multiply
  assign ini_prod = 28'(g1_q.s) * 28'(RECIP_588);
  assign t_prod   = 26'(g1_q.s[13:2]) * 26'(RECIP_7);

  always_comb begin
    g2_d.is_syl = g1_q.is_syl;
    g2_d.nraw   = g1_q.nraw;
    g2_d.b0     = g1_q.b0;
    g2_d.b1     = g1_q.b1;
    g2_d.b2     = g1_q.b2;
    g2_d.last   = g1_q.last;
    g2_d.ini    = ini_prod[27:23];
    g2_d.t      = t_prod[24:16];
    g2_d.u      = g1_q.s[13:2];
    g2_d.s_lo   = g1_q.s[1:0];
  end

  uhjs_jamo_expand u_expand (
    .grp_i (g2_q),
    .res_o (exp_res),
    .cnt_o (exp_cnt)
  );

  always_comb begin
    g1_valid_d = g1_free ? (accept && grp_valid) : g1_valid_q;
    g2_valid_d = g2_free ? g1_valid_q : g2_valid_q;
    res_d      = res_q;
    rcnt_d     = rcnt_q;
    if (g2_valid_q && load_ok) begin
      res_d  = exp_res;
      rcnt_d = exp_cnt;
    end else if (take) begin
      res_d[0] = res_q[1];
      res_d[1] = res_q[2];
      rcnt_d   = rcnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win0_q     <= 8'd0;
      win1_q     <= 8'd0;
      wcnt_q     <= 2'd0;
      g1_valid_q <= 1'b0;
      g2_valid_q <= 1'b0;
      rcnt_q     <= 2'd0;
    end else begin
      win0_q     <= win0_d;
      win1_q     <= win1_d;
      wcnt_q     <= wcnt_d;
      g1_valid_q <= g1_valid_d;
      g2_valid_q <= g2_valid_d;
      rcnt_q     <= rcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && grp_valid) begin
      g1_q <= grp;
    end
    if (g2_free && g1_valid_q) begin
      g2_q <= g2_d;
    end
    res_q <= res_d;
  end

endmodule

`default_nettype wire

>>> dv/tb.sv
// testbench for the utf8 hangul jamo splitter: directed and random byte streams
`timescale 1ns / 1ps

module tb;
  import uhjs_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned DRAIN_CYCLES = 20;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  uhjs_in_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  uhjs_out_t out_data_o;

  utf8_hangul_jamo_splitter_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // compatibility jamo code points, stored as offsets from 0x3130
  logic [7:0] initial_ofs [0:18] = '{
    8'h01, 8'h02, 8'h04, 8'h07, 8'h08, 8'h09, 8'h11, 8'h12, 8'h13, 8'h15,
    8'h16, 8'h17, 8'h18, 8'h19, 8'h1A, 8'h1B, 8'h1C, 8'h1D, 8'h1E
  };
  logic [7:0] final_ofs [0:27] = '{
    8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h09, 8'h0A,
    8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F, 8'h10, 8'h11, 8'h12, 8'h14, 8'h15,
    8'h16, 8'h17, 8'h18, 8'h1A, 8'h1B, 8'h1C, 8'h1D, 8'h1E
  };

  // byte window mirrored from the block
  logic [7:0]  win_q [0:1] = '{8'h00, 8'h00};
  logic [1:0]  win_cnt     = 2'd0;
  uhjs_out_t   jamo_q [$];
  uhjs_in_t    pending [$];

  int unsigned mismatches = 0;
  int unsigned cycles     = 0;
  logic        idle_on    = 1'b1;
  logic        in_taken   = 1'b0;
  int unsigned send_gap   = 0;
  int unsigned stall_left = 0;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // expected jamo / raw items caused by one accepted byte
  task automatic split_byte(input logic [7:0] b, input logic lst);
    logic [7:0]  seq [0:2];
    uhjs_out_t   step_q [$];
    uhjs_out_t   r;
    logic [15:0] cp;
    int unsigned n, pos, s, ini, med, fin;
    seq[0] = win_q[0];
    seq[1] = win_q[1];
    seq[2] = 8'h00;
    n = win_cnt;
    seq[n] = b;
    n++;
    pos = 0;
    while (n - pos == 3 || (lst && pos < n)) begin
      // a full window always starts at position 0
      cp = {seq[0][3:0], seq[1][5:0], seq[2][5:0]};
      if (n - pos == 3 && seq[0][7:4] == LEAD_3BYTE && cp >= SYL_FIRST
          && cp <= SYL_LAST) begin
        s = cp - SYL_FIRST;
        ini = s / 588;
        med = (s % 588) / 28;
        fin = s % 28;
        r.out_last   = 1'b0;
        r.kind       = KIND_INITIAL;
        r.jamo_index = 5'(ini);
        r.code_value = 14'h3130 + 14'(initial_ofs[ini]);
        step_q.insert(step_q.size(), r);
        r.kind       = KIND_MEDIAL;
        r.jamo_index = 5'(med);
        r.code_value = MEDIAL_BASE + 14'(med);
        step_q.insert(step_q.size(), r);
        if (fin != 0) begin
          r.kind       = KIND_FINAL;
          r.jamo_index = 5'(fin);
          r.code_value = 14'h3130 + 14'(final_ofs[fin]);
          step_q.insert(step_q.size(), r);
        end
        pos += 3;
      end else begin
        r.kind       = KIND_RAW;
        r.jamo_index = 5'd0;
        r.code_value = {6'd0, seq[pos]};
        r.out_last   = 1'b0;
        step_q.insert(step_q.size(), r);
        pos++;
      end
      if (!lst) break;
    end
    n -= pos;
    win_q[0] = (n > 0) ? seq[pos] : 8'h00;
    win_q[1] = (n > 1) ? seq[pos + 1] : 8'h00;
    win_cnt  = 2'(n);
    if (lst && step_q.size() != 0) step_q[step_q.size() - 1].out_last = 1'b1;
    foreach (step_q[i]) jamo_q.insert(jamo_q.size(), step_q[i]);
  endtask

  task automatic push_byte(input logic [7:0] b, input logic lst);
    uhjs_in_t item;
    item.in_byte = b;
    item.in_last = lst;
    pending.insert(pending.size(), item);
  endtask

  // random texts, mostly well-formed syllables, ended by a last flag
  task automatic add_texts(input int unsigned target);
    logic [7:0]  text [$];
    logic [15:0] cp;
    int unsigned added, units, u, pick;
    added = 0;
    while (added < target) begin
      text.delete();
      units = $urandom_range(1, 8);
      for (u = 0; u < units; u++) begin
        pick = $urandom_range(0, 99);
        cp = 16'($urandom_range(SYL_FIRST, SYL_LAST));
        if (pick < 60) begin
          text.insert(text.size(), {4'hE, cp[15:12]});
          text.insert(text.size(), {2'b10, cp[11:6]});
          text.insert(text.size(), {2'b10, cp[5:0]});
        end else if (pick < 75) begin
          text.insert(text.size(), 8'($urandom_range(8'h20, 8'h7E)));
        end else if (pick < 85) begin
          text.insert(text.size(), 8'($urandom));
        end else if (pick < 92) begin
          // syllable cut short
          text.insert(text.size(), {4'hE, cp[15:12]});
          if ($urandom_range(0, 1) != 0) text.insert(text.size(), {2'b10, cp[11:6]});
        end else begin
          // lead byte followed by arbitrary bytes, continuation not checked
          text.insert(text.size(), {4'hE, 4'($urandom)});
          text.insert(text.size(), 8'($urandom));
          text.insert(text.size(), 8'($urandom));
        end
      end
      foreach (text[i]) push_byte(text[i], i == text.size() - 1);
      added += text.size();
    end
  endtask

  task automatic wait_sent();
    while (pending.size() != 0 || in_valid_i) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (jamo_q.size() != 0) @(posedge clk_i);
  endtask

  // driver: inputs change on the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (send_gap != 0) begin
          in_valid_i <= 1'b0;
          send_gap   <= send_gap - 1;
        end else if (pending.size() != 0) begin
          in_data_i  <= pending.pop_front();
          in_valid_i <= 1'b1;
          send_gap   <= idle_on ? pick_gap() : 0;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left  <= stall_left - 1;
      end else begin
        out_stall_i <= 1'b0;
        stall_left  <= idle_on ? pick_gap() : 0;
      end
    end
  end

  // monitor: handshakes sampled on the rising edge
  always @(posedge clk_i) begin
    uhjs_out_t want;
    if (rst_ni) begin
      cycles++;
      if (out_valid_o && !out_stall_i) begin
        if (jamo_q.size() == 0) begin
          mismatches++;
          $display({"%0t mismatch: expected no item,",
                    " got kind %0d index %0d code %h last %b"},
                   $time, out_data_o.kind, out_data_o.jamo_index,
                   out_data_o.code_value, out_data_o.out_last);
        end else begin
          want = jamo_q.pop_front();
          if (want.kind != out_data_o.kind || want.jamo_index != out_data_o.jamo_index
              || want.code_value != out_data_o.code_value
              || want.out_last != out_data_o.out_last) begin
            mismatches++;
            $display({"%0t mismatch: expected kind %0d index %0d code %h last %b,",
                      " got kind %0d index %0d code %h last %b"},
                     $time, want.kind, want.jamo_index, want.code_value,
                     want.out_last, out_data_o.kind, out_data_o.jamo_index,
                     out_data_o.code_value, out_data_o.out_last);
          end
        end
      end
      in_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) split_byte(in_data_i.in_byte, in_data_i.in_last);
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // zero byte, first syllable with no final, last syllable, ascii end
    push_byte(8'h00, 1'b0);
    push_byte(8'hEA, 1'b0);
    push_byte(8'hB0, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hED, 1'b0);
    push_byte(8'h9E, 1'b0);
    push_byte(8'hA3, 1'b0);
    push_byte(8'h41, 1'b1);
    // just above and just below the syllable range
    push_byte(8'hED, 1'b0);
    push_byte(8'h9E, 1'b0);
    push_byte(8'hA4, 1'b0);
    push_byte(8'hEA, 1'b0);
    push_byte(8'hAF, 1'b0);
    push_byte(8'hBF, 1'b1);
    // one-byte text
    push_byte(8'hFF, 1'b1);
    // lead byte as the final byte
    push_byte(8'h41, 1'b0);
    push_byte(8'hEA, 1'b1);
    // bad continuation bytes still decode, then lead with two bytes left
    push_byte(8'hEA, 1'b0);
    push_byte(8'h30, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hEA, 1'b0);
    push_byte(8'hB0, 1'b1);
    // syllable with a final completed by the last byte
    push_byte(8'hEC, 1'b0);
    push_byte(8'h95, 1'b0);
    push_byte(8'h88, 1'b1);
    wait_sent();
    wait_drained();

    add_texts(150);
    // hold the sender until the output side has caught up
    wait_sent();
    wait_drained();

    idle_on = 1'b0;
    add_texts(60);
    wait_sent();
    idle_on = 1'b1;
    add_texts(75);
    wait_sent();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && jamo_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      if (jamo_q.size() != 0) $display("%0t %0d expected items never came", $time,
                                       jamo_q.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
